// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh - clocked assertion helpers for the servo sequencer
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at each rising edge, off while reset is low.
`define SPS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be seen at a rising edge.
`define SPS_NEVER(label, clk, rst_n, expr, msg) \
    `SPS_ASSERT(label, clk, rst_n, !(expr), msg)

`endif

// ----- rtl/sps_pkg.sv -----
// ---------------------------------------------------------------------------
// sps_pkg - shared types and constants of the servo pulse sequencer
// Field widths, reset values, request codes and inter-module structs.
// ---------------------------------------------------------------------------
package sps_pkg;

    localparam int TICK_W = 16;
    localparam int US_W   = 16;
    localparam int CH_W   = 8;
    localparam int CFG_W  = 15;

    localparam int CHANNELS_PER_BANK_DEF = 10;

    localparam logic [TICK_W-1:0] START_DELAY_TICKS = 16'd4000;
    localparam logic [CFG_W-1:0]  MIN_US_RESET      = 15'd1000;
    localparam logic [CFG_W-1:0]  MAX_US_RESET      = 15'd2000;

    typedef enum logic {
        MODE_TICK  = 1'b0,
        MODE_WRITE = 1'b1
    } t_mode;

    typedef enum logic {
        REG_MIN_US = 1'b0,
        REG_MAX_US = 1'b1
    } t_reg_idx;

    // Pulse request raised by one bank for the current tick.
    typedef struct packed {
        logic clock_pulse;
        logic reset_pulse;
    } t_bank_evt;

    typedef struct packed {
        logic clock_a;
        logic reset_a;
        logic clock_b;
        logic reset_b;
        logic write_ignored;
    } t_result;

endpackage

// ----- rtl/sps_bank.sv -----
// ---------------------------------------------------------------------------
// sps_bank - one servo bank: width memory, channel pointer, compare value
// Reads the width on a compare hit and loads the new compare in the following cycle.
// ---------------------------------------------------------------------------
module sps_bank #(
    parameter int CHANNELS_PER_BANK = sps_pkg::CHANNELS_PER_BANK_DEF,
    parameter logic [sps_pkg::TICK_W-1:0] CMP_RESET = '0,
    localparam int AW = $clog2(CHANNELS_PER_BANK),
    localparam int SW = $clog2(CHANNELS_PER_BANK + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_tick,
    input  logic [sps_pkg::TICK_W-1:0]    i_count,
    input  logic                          i_wr_en,
    input  logic [AW-1:0]                 i_wr_addr,
    input  logic [sps_pkg::TICK_W-1:0]    i_wr_width,
    output sps_pkg::t_bank_evt            o_evt
);
    import sps_pkg::*;

    localparam logic [SW-1:0] PAST_LAST = SW'(CHANNELS_PER_BANK);

    logic [TICK_W-1:0]            r_width_mem [CHANNELS_PER_BANK];
    logic [CHANNELS_PER_BANK-1:0] r_written;
    logic [SW-1:0]                r_cur;
    logic [TICK_W-1:0]            r_cmp;
    logic                         r_pend;
    logic [TICK_W-1:0]            r_rd_width;
    logic                         r_rd_written;

    logic              hit;
    logic              wrap;
    logic [AW-1:0]     ch;
    logic [TICK_W-1:0] fire_tick;
    logic [TICK_W-1:0] width;
    logic [TICK_W-1:0] n_cmp;

    // A compare reload in flight blocks a hit; widths are even, so the
    // tick right after a hit can never match the new compare anyway.
    assign hit       = i_tick && !r_pend && (i_count == r_cmp);
    assign wrap      = (r_cur >= PAST_LAST);
    assign ch        = wrap ? '0 : r_cur[AW-1:0];
    // Count has already advanced past the firing tick.
    assign fire_tick = i_count - TICK_W'(1);
    assign width     = r_rd_written ? r_rd_width : '0;
    assign n_cmp     = fire_tick + width;

    assign o_evt.clock_pulse = hit && !wrap;
    assign o_evt.reset_pulse = hit && wrap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur     <= '0;
            r_cmp     <= CMP_RESET;
            r_pend    <= 1'b0;
            r_written <= '0;
        end else begin
            r_pend <= hit;
            if (hit) begin
                r_cur <= SW'(ch) + SW'(1);
            end
            if (r_pend) begin
                r_cmp <= n_cmp;
            end
            if (i_wr_en) begin
                r_written[i_wr_addr] <= 1'b1;
            end
        end
    end

    // Width memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_width_mem[i_wr_addr] <= i_wr_width;
        end
        if (hit) begin
            r_rd_width   <= r_width_mem[ch];
            r_rd_written <= r_written[ch];
        end
    end

endmodule

// ----- rtl/servo_pulse_sequencer_unit.sv -----
// ---------------------------------------------------------------------------
// servo_pulse_sequencer_unit - two-bank servo pulse sequencer, 4017 style
// Results are registered, with a skid register behind a stalled output.
// Throughput: one request per cycle while the skid register is empty.
// Reset: synchronous; clears counts, width valid bits; sets compares, clamps.
// ---------------------------------------------------------------------------
module servo_pulse_sequencer_unit #(
    parameter int CHANNELS_PER_BANK = sps_pkg::CHANNELS_PER_BANK_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_mode,
    input  logic [sps_pkg::CH_W-1:0]    i_channel,
    input  logic [sps_pkg::US_W-1:0]    i_pulse_us,
    // result channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_clock_a,
    output logic                        o_reset_a,
    output logic                        o_clock_b,
    output logic                        o_reset_b,
    output logic                        o_write_ignored,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import sps_pkg::*;

    localparam int AW = $clog2(CHANNELS_PER_BANK);
    localparam logic [CH_W-1:0] BANK_B_BASE = CH_W'(CHANNELS_PER_BANK);
    localparam logic [CH_W-1:0] CH_END      = CH_W'(2 * CHANNELS_PER_BANK);

    // -----------------------------------------------------------------------
    // Configuration registers: clamp limits in microseconds.
    // -----------------------------------------------------------------------
    logic [CFG_W-1:0] r_min_us;
    logic [CFG_W-1:0] r_max_us;
    t_reg_idx         reg_idx;
    logic             cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_us <= MIN_US_RESET;
            r_max_us <= MAX_US_RESET;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_MIN_US: r_min_us <= pwdata[CFG_W-1:0];
                REG_MAX_US: r_max_us <= pwdata[CFG_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MIN_US: prdata = 32'(r_min_us);
            REG_MAX_US: prdata = 32'(r_max_us);
            default:    prdata = '0;
        endcase
    end

    // -----------------------------------------------------------------------
    // Request decode. The skid register is the only thing that stalls the
    // request side, so a request is taken while a result still waits.
    // -----------------------------------------------------------------------
    logic r_skid_vld;
    logic in_acc;
    logic is_tick;
    logic is_write;
    logic in_bank_a;
    logic in_bank_b;
    logic wr_ignored;

    assign o_stall    = r_skid_vld;
    assign in_acc     = i_valid && !r_skid_vld;
    assign is_tick    = in_acc && (t_mode'(i_mode) == MODE_TICK);
    assign is_write   = in_acc && (t_mode'(i_mode) == MODE_WRITE);
    assign in_bank_a  = (i_channel < BANK_B_BASE);
    assign in_bank_b  = !in_bank_a && (i_channel < CH_END);
    assign wr_ignored = is_write && !in_bank_a && !in_bank_b;

    // Clamp: the minimum wins when it is tested first, then the maximum.
    logic [US_W-1:0]   clamp_us;
    logic [TICK_W-1:0] wr_width;
    logic [AW-1:0]     addr_a;
    logic [AW-1:0]     addr_b;
    logic [CH_W-1:0]   ch_off_b;

    always_comb begin
        if (i_pulse_us < US_W'(r_min_us)) begin
            clamp_us = US_W'(r_min_us);
        end else if (i_pulse_us > US_W'(r_max_us)) begin
            clamp_us = US_W'(r_max_us);
        end else begin
            clamp_us = i_pulse_us;
        end
    end

    // Two ticks per microsecond; drop the carry out of bit 15.
    assign wr_width = {clamp_us[US_W-2:0], 1'b0};
    assign ch_off_b = i_channel - BANK_B_BASE;
    assign addr_a   = i_channel[AW-1:0];
    assign addr_b   = ch_off_b[AW-1:0];

    // -----------------------------------------------------------------------
    // Shared free-running tick counter; advance on tick requests only.
    // -----------------------------------------------------------------------
    logic [TICK_W-1:0] r_count;
    logic [TICK_W-1:0] n_count;

    assign n_count = r_count + TICK_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (is_tick) begin
            r_count <= n_count;
        end
    end

    // -----------------------------------------------------------------------
    // Banks. Each compares against the count before it advances and owns
    // its width memory; bank A starts after the power-up delay.
    // -----------------------------------------------------------------------
    t_bank_evt evt_a;
    t_bank_evt evt_b;

    sps_bank #(
        .CHANNELS_PER_BANK (CHANNELS_PER_BANK),
        .CMP_RESET         (START_DELAY_TICKS)
    ) u_bank_a (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tick     (is_tick),
        .i_count    (r_count),
        .i_wr_en    (is_write && in_bank_a),
        .i_wr_addr  (addr_a),
        .i_wr_width (wr_width),
        .o_evt      (evt_a)
    );

    sps_bank #(
        .CHANNELS_PER_BANK (CHANNELS_PER_BANK),
        .CMP_RESET         ('0)
    ) u_bank_b (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tick     (is_tick),
        .i_count    (r_count),
        .i_wr_en    (is_write && in_bank_b),
        .i_wr_addr  (addr_b),
        .i_wr_width (wr_width),
        .o_evt      (evt_b)
    );

    // -----------------------------------------------------------------------
    // Result register plus skid register. Pulses are zero on write requests
    // because the banks only hit on ticks.
    // -----------------------------------------------------------------------
    t_result res;
    t_result r_out;
    t_result r_skid;
    logic    r_out_vld;
    logic    out_take;

    assign res.clock_a       = evt_a.clock_pulse;
    assign res.reset_a       = evt_a.reset_pulse;
    assign res.clock_b       = evt_b.clock_pulse;
    assign res.reset_b       = evt_b.reset_pulse;
    assign res.write_ignored = wr_ignored;

    assign out_take = r_out_vld && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (out_take || !r_out_vld) begin
            if (r_skid_vld) begin
                // drain the skid first; no request is taken meanwhile
                r_out      <= r_skid;
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld <= in_acc;
                if (in_acc) begin
                    r_out <= res;
                end
            end
        end else if (in_acc) begin
            // hold the new result aside while the output is stalled
            r_skid     <= res;
            r_skid_vld <= 1'b1;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_clock_a       = r_out.clock_a;
    assign o_reset_a       = r_out.reset_a;
    assign o_clock_b       = r_out.clock_b;
    assign o_reset_b       = r_out.reset_b;
    assign o_write_ignored = r_out.write_ignored;

endmodule

// ----- rtl/sps_checker.sv -----
// ---------------------------------------------------------------------------
// sps_checker - port-level checks of the servo pulse sequencer
// Watches results and stall behavior on the top-level ports.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sps_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input logic o_clock_a,
    input logic o_reset_a,
    input logic o_clock_b,
    input logic o_reset_b,
    input logic o_write_ignored
);

    `SPS_NEVER(a_bank_a_one_pulse, i_clk, i_rst_n, o_valid && o_clock_a && o_reset_a, "bank A clock and reset in one result")
    `SPS_NEVER(a_bank_b_one_pulse, i_clk, i_rst_n, o_valid && o_clock_b && o_reset_b, "bank B clock and reset in one result")
    `SPS_NEVER(a_ignored_no_pulse, i_clk, i_rst_n, o_valid && o_write_ignored && (o_clock_a || o_reset_a || o_clock_b || o_reset_b), "ignored write carries a pulse")
    `SPS_ASSERT(a_stall_cause, i_clk, i_rst_n, $rose(o_stall) |-> $past(o_valid && i_stall), "request stall without a held result")
    `SPS_ASSERT(a_result_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_clock_a) && $stable(o_reset_a) && $stable(o_clock_b) && $stable(o_reset_b) && $stable(o_write_ignored), "stalled result changed")

endmodule

bind servo_pulse_sequencer_unit sps_checker u_sps_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_clock_a       (o_clock_a),
    .o_reset_a       (o_reset_a),
    .o_clock_b       (o_clock_b),
    .o_reset_b       (o_reset_b),
    .o_write_ignored (o_write_ignored)
);

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench - servo pulse sequencer, self-checking
// Drives tick and width-write requests, keeps its own copy of the width table,
// bank channels, compares and tick counter, and checks every result in order.
// ---------------------------------------------------------------------------
module testbench;

    import sps_pkg::*;

    localparam int BANK_CH     = CHANNELS_PER_BANK_DEF;
    localparam int TABLE_LEN   = 2 * BANK_CH;
    localparam int QUIET_LIMIT = 2000;   // far above the longest hold-off

    // -----------------------------------------------------------------------
    // Clock, reset and block inputs, all known from time zero
    // -----------------------------------------------------------------------
    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_valid    = 1'b0;
    logic              i_mode     = 1'b0;
    logic [CH_W-1:0]   i_channel  = '0;
    logic [US_W-1:0]   i_pulse_us = '0;
    logic              i_stall    = 1'b0;
    logic              psel       = 1'b0;
    logic              penable    = 1'b0;
    logic              pwrite     = 1'b0;
    logic [2:0]        paddr      = '0;
    logic [31:0]       pwdata     = '0;

    logic              o_stall;
    logic              o_valid;
    logic              o_clock_a;
    logic              o_reset_a;
    logic              o_clock_b;
    logic              o_reset_b;
    logic              o_write_ignored;
    logic [31:0]       prdata;
    logic              pready;

    always #10 i_clk = ~i_clk;

    servo_pulse_sequencer_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_mode          (i_mode),
        .i_channel       (i_channel),
        .i_pulse_us      (i_pulse_us),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_clock_a       (o_clock_a),
        .o_reset_a       (o_reset_a),
        .o_clock_b       (o_clock_b),
        .o_reset_b       (o_reset_b),
        .o_write_ignored (o_write_ignored),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // -----------------------------------------------------------------------
    // Sequencer copy: widths, bank positions, compares, tick count, clamps.
    // Starts from the reset state; clamps track every register write.
    // -----------------------------------------------------------------------
    logic [TICK_W-1:0] width_tbl [TABLE_LEN] = '{default: '0};
    logic [4:0]        chan_a    = '0;     // counts 0..BANK_CH, BANK_CH = past last
    logic [4:0]        chan_b    = '0;
    logic [TICK_W-1:0] tick_now  = '0;
    logic [TICK_W-1:0] cmp_a     = START_DELAY_TICKS;
    logic [TICK_W-1:0] cmp_b     = '0;
    logic [CFG_W-1:0]  clamp_lo  = MIN_US_RESET;
    logic [CFG_W-1:0]  clamp_hi  = MAX_US_RESET;

    t_result expected_pulses [$];

    // Pacing of both sides; the test tasks switch these per stretch.
    bit pace_in  = 1'b1;
    bit pace_out = 1'b1;
    int hold_off_req = 0;     // long receiver hold-off, picked up by the checker

    int mismatch_count = 0;
    int quiet_cycles   = 0;
    int stall_gap      = 0;
    int hold_left      = 0;

    t_result seen;
    t_result want;
    string   field_name [5] = '{"write_ignored", "reset_b", "clock_b", "reset_a", "clock_a"};

    // Service one bank on a compare match; return 1 when it wraps to channel 0.
    function automatic logic fire_bank(inout logic [4:0] chan,
                                       inout logic [TICK_W-1:0] cmp,
                                       input int base);
        logic wrapped;
        wrapped = (chan >= BANK_CH);
        if (wrapped) begin
            chan = '0;
        end
        cmp  = tick_now + width_tbl[base + chan];
        chan = chan + 1'b1;
        return wrapped;
    endfunction

    // Work out the result of one accepted request and advance the copy.
    function automatic t_result predict_result(input t_mode mode,
                                               input logic [CH_W-1:0] ch,
                                               input logic [US_W-1:0] us);
        t_result         res;
        logic [US_W-1:0] held;
        res = '0;
        if (mode == MODE_WRITE) begin
            if (ch >= TABLE_LEN) begin
                res.write_ignored = 1'b1;
            end else begin
                // Minimum wins when the clamps cross.
                held = us;
                if (held < US_W'(clamp_lo)) begin
                    held = US_W'(clamp_lo);
                end else if (held > US_W'(clamp_hi)) begin
                    held = US_W'(clamp_hi);
                end
                width_tbl[ch] = {held[US_W-2:0], 1'b0};
            end
        end else begin
            // Both banks compare against the count before it advances.
            if (tick_now == cmp_a) begin
                if (fire_bank(chan_a, cmp_a, 0)) begin
                    res.reset_a = 1'b1;
                end else begin
                    res.clock_a = 1'b1;
                end
            end
            if (tick_now == cmp_b) begin
                if (fire_bank(chan_b, cmp_b, BANK_CH)) begin
                    res.reset_b = 1'b1;
                end else begin
                    res.clock_b = 1'b1;
                end
            end
            tick_now = tick_now + 1'b1;
        end
        return res;
    endfunction

    // -----------------------------------------------------------------------
    // Request side. Valid stays high after acceptance so that a back-to-back
    // request needs a single assignment; anything that pauses drops it first.
    // -----------------------------------------------------------------------
    task automatic offer_request(input t_mode mode,
                                 input logic [CH_W-1:0] ch,
                                 input logic [US_W-1:0] us);
        int gap;
        gap = pace_in ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_mode     <= mode;
        i_channel  <= ch;
        i_pulse_us <= us;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_pulses.push_back(predict_result(mode, ch, us));
    endtask

    // Drop valid and hold until every expected result is back.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_pulses.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Setup cycle, then access cycle; only done with the block idle.
    task automatic write_clamp(input t_reg_idx idx, input logic [CFG_W-1:0] value);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {17'($urandom), value};   // upper bits are not part of the register
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_MIN_US) begin
            clamp_lo = value;
        end else begin
            clamp_hi = value;
        end
    endtask

    // Mostly ticks; writes hit mostly real channels, widths small, in range or random.
    task automatic offer_random_request();
        logic [CH_W-1:0] ch;
        logic [US_W-1:0] us;
        ch = CH_W'($urandom);
        us = US_W'($urandom);
        if ($urandom_range(0, 99) < 25) begin
            if ($urandom_range(0, 99) < 85) begin
                ch = CH_W'($urandom_range(0, TABLE_LEN - 1));
            end
            case ($urandom_range(0, 3))
                0: us = US_W'($urandom_range(0, 20));
                1: if (clamp_lo <= clamp_hi) begin
                    us = US_W'($urandom_range(clamp_lo, clamp_hi));
                end
                default: ;
            endcase
            offer_request(MODE_WRITE, ch, us);
        end else begin
            offer_request(MODE_TICK, ch, us);
        end
    endtask

    // -----------------------------------------------------------------------
    // Result side: check each accepted result against the oldest expectation,
    // then draw the stall before the next one. A long hold-off overrides it.
    // -----------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            seen = {o_clock_a, o_reset_a, o_clock_b, o_reset_b, o_write_ignored};
            if (expected_pulses.size() == 0) begin
                mismatch_count++;
                $display("%0t: result expected none actual %b", $time, seen);
            end else begin
                want = expected_pulses.pop_front();
                for (int b = 4; b >= 0; b--) begin
                    if (want[b] !== seen[b]) begin
                        mismatch_count++;
                        $display("%0t: %s expected %b actual %b", $time,
                                 field_name[b], want[b], seen[b]);
                    end
                end
            end
            stall_gap = pace_out ? $urandom_range(0, 9) : 0;
        end
        if (hold_off_req > 0) begin
            hold_left    = hold_off_req;
            hold_off_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (stall_gap > 0) begin
            stall_gap--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)
                || (psel && penable && pwrite && pready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
                $display("servo_pulse_sequencer_unit: mismatch");
                $finish;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    // Clamp edges at reset clamps, crossed clamps and full-range clamps,
    // out-of-range channels, then the first few ticks.
    task automatic test_directed();
        offer_request(MODE_WRITE, CH_W'(0), 16'd0);                 // below minimum
        offer_request(MODE_WRITE, CH_W'(TABLE_LEN - 1), 16'hFFFF);  // above maximum
        offer_request(MODE_WRITE, CH_W'(5), 16'd1500);              // kept as is
        offer_request(MODE_WRITE, CH_W'(TABLE_LEN), 16'd1234);      // first channel past B
        offer_request(MODE_WRITE, 8'hFF, 16'hFFFF);                 // top channel

        // Minimum above maximum: the minimum test runs first.
        write_clamp(REG_MIN_US, 15'h7FFF);
        write_clamp(REG_MAX_US, 15'd0);
        offer_request(MODE_WRITE, CH_W'(1), 16'd100);
        offer_request(MODE_WRITE, CH_W'(2), 16'hFFFF);
        offer_request(MODE_WRITE, CH_W'(3), 16'h7FFF);

        write_clamp(REG_MIN_US, 15'd0);
        write_clamp(REG_MAX_US, 15'h7FFF);
        offer_request(MODE_WRITE, CH_W'(4), 16'd0);
        offer_request(MODE_WRITE, CH_W'(6), 16'h7FFF);
        offer_request(MODE_WRITE, CH_W'(7), 16'hFFFF);
        offer_request(MODE_WRITE, CH_W'(BANK_CH), 16'd3);

        // Bank B matches on the very first tick; stop before its next match.
        repeat (5) offer_request(MODE_TICK, CH_W'($urandom), US_W'($urandom));
    endtask

    // Fill every width with short pulses, then tick past the bank A start delay.
    task automatic test_start_delay();
        write_clamp(REG_MIN_US, 15'd1);
        write_clamp(REG_MAX_US, 15'd8);
        for (int c = 0; c < TABLE_LEN; c++) begin
            offer_request(MODE_WRITE, CH_W'(c), US_W'($urandom_range(0, 12)));
        end
        pace_in = 1'b0;
        while (tick_now != START_DELAY_TICKS + 16'd40) begin
            offer_request(MODE_TICK, CH_W'($urandom), US_W'($urandom));
        end
        pace_in = 1'b1;
    endtask

    // Several clamp settings, crossed ones among them; the first phase runs
    // at full rate, the rest switch pacing every 50 requests.
    task automatic test_random_phases();
        for (int p = 0; p < 5; p++) begin
            write_clamp(REG_MIN_US, CFG_W'($urandom_range(1, 6)));
            write_clamp(REG_MAX_US, CFG_W'($urandom_range(1, 12)));
            for (int n = 0; n < 200; n++) begin
                if (n % 50 == 0) begin
                    pace_in  = (p != 0) && ($urandom_range(0, 3) != 0);
                    pace_out = (p != 0) && ($urandom_range(0, 3) != 0);
                end
                offer_random_request();
            end
        end
        pace_in  = 1'b1;
        pace_out = 1'b1;
    endtask

    // Hold the result side off while requests keep coming at full rate.
    task automatic test_backpressure();
        pace_in      = 1'b0;
        hold_off_req = 80;
        repeat (40) offer_random_request();
        pace_in      = 1'b1;
    endtask

    // Short bursts, each followed by a full drain.
    task automatic test_pause_between_bursts();
        repeat (6) begin
            repeat ($urandom_range(1, 12)) offer_random_request();
            wait_drained();
        end
    endtask

    // Zero widths everywhere: a bank that matches reloads its compare with
    // the current count and stays quiet for the rest of the stretch.
    task automatic test_counter_wrap();
        write_clamp(REG_MIN_US, 15'd0);
        write_clamp(REG_MAX_US, 15'd0);
        for (int c = 0; c < TABLE_LEN; c++) begin
            offer_request(MODE_WRITE, CH_W'(c), US_W'($urandom));
        end
        pace_in  = 1'b0;
        pace_out = 1'b0;
        repeat (200) offer_request(MODE_TICK, CH_W'($urandom), US_W'($urandom));
        pace_in  = 1'b1;
        pace_out = 1'b1;
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_start_delay();
        test_random_phases();
        test_backpressure();
        test_pause_between_bursts();
        test_counter_wrap();

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && expected_pulses.size() == 0) begin
            $display("servo_pulse_sequencer_unit: match");
        end else begin
            $display("servo_pulse_sequencer_unit: mismatch");
        end
        $finish;
    end

endmodule
